// File: src/p3d_pkg.sv
// Shared types and constants for the pseudo-3D road segment projector.
`default_nettype none

package p3d_pkg;

  // Configuration write data width, set by the widest register (camera_x)
  localparam int CFG_DATA_W = 21;

  // Register reset values
  localparam logic signed [20:0] CAMERA_X_RST     = 21'sd0;
  localparam logic signed [16:0] CAMERA_Y_RST     = 17'sd1500;
  localparam logic [19:0]        CAMERA_Z_RST     = 20'd0;
  localparam logic [19:0]        TRACK_LENGTH_RST = 20'd320000;
  localparam logic [15:0]        FOCAL_DEPTH_RST  = 16'd55050;
  localparam logic [11:0]        SCREEN_W_RST     = 12'd1024;
  localparam logic [11:0]        SCREEN_H_RST     = 12'd768;
  localparam logic [15:0]        ROAD_WIDTH_RST   = 16'd2000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CAMERA_X,
    REG_CAMERA_Y,
    REG_CAMERA_Z,
    REG_TRACK_LENGTH,
    REG_FOCAL_DEPTH,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT,
    REG_ROAD_WIDTH
  } cfg_reg_t;

  // Projection operations that share the multiplier pair
  typedef enum logic [1:0] {
    OP_X,
    OP_Y,
    OP_W
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic m1_en;
    op_t  m1_op;
    logic m2_en;
    op_t  m2_op;
    logic sat_en;
    op_t  sat_op;
    logic commit;
  } p3d_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dz_ok;
    logic out_free;
  } p3d_sts_t;

endpackage

`default_nettype wire

// File: src/p3d_ctrl.sv
// Controller state machine: sequences prepare, divide, multiply and commit.
`default_nettype none

module p3d_ctrl #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  p3d_pkg::p3d_sts_t   sts,
  output p3d_pkg::p3d_cmd_t   cmd
);
  import p3d_pkg::*;

  localparam int CW = $clog2(SCALE_FRAC_BITS);
  localparam logic [CW-1:0] DIV_LAST = CW'(SCALE_FRAC_BITS - 1);
  localparam logic [2:0]    MUL_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] div_cnt_r, div_cnt_nxt;
  logic [2:0]    mul_cnt_r, mul_cnt_nxt;

  // Map a pipeline slot to its projection operation
  function automatic op_t op_of(input logic [2:0] k);
    op_t o;
    case (k)
      3'd0:    o = OP_X;
      3'd1:    o = OP_Y;
      default: o = OP_W;
    endcase
    return o;
  endfunction

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    mul_cnt_nxt = mul_cnt_r;
    cmd         = '0;
    cmd.m1_op   = op_of(mul_cnt_r);
    cmd.m2_op   = op_of(mul_cnt_r - 3'd1);
    cmd.sat_op  = op_of(mul_cnt_r - 3'd2);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.dz_ok) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
          div_cnt_nxt  = div_cnt_r + CW'(1);
          if (div_cnt_r == DIV_LAST) begin
            mul_cnt_nxt = '0;
            state_nxt   = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.m1_en   = (mul_cnt_r < 3'd3);
        cmd.m2_en   = (mul_cnt_r >= 3'd1) && (mul_cnt_r <= 3'd3);
        cmd.sat_en  = (mul_cnt_r >= 3'd2);
        mul_cnt_nxt = mul_cnt_r + 3'd1;
        if (mul_cnt_r == MUL_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      mul_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      mul_cnt_r <= mul_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/p3d_dpath.sv
// Datapath: registers, curve state, restoring divider, projection multipliers.
`default_nettype none

module p3d_dpath #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  p3d_pkg::p3d_cmd_t                   cmd,
  output p3d_pkg::p3d_sts_t                   sts,
  input  logic                                cfg_valid,
  input  p3d_pkg::cfg_reg_t                   cfg_index,
  input  logic [p3d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [15:0]                  in_seg_height,
  input  logic [19:0]                         in_seg_depth,
  input  logic signed [15:0]                  in_seg_curve,
  input  logic                                in_wrapped,
  input  logic                                in_frame_start,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [15:0]                  out_screen_x,
  output logic signed [15:0]                  out_screen_y,
  output logic [15:0]                         out_screen_half_width,
  output logic [23:0]                         out_proj_scale,
  output logic signed [15:0]                  out_clip_line,
  output logic                                out_visible,
  output logic                                out_depth_ok
);
  import p3d_pkg::*;

  localparam int S   = SCALE_FRAC_BITS;
  localparam int P1W = S + 27;
  localparam int VW  = S + 28;
  localparam int VCW = S + 19;
  localparam int P2W = S + 32;
  localparam logic signed [VW-1:0] V_ONE  = VW'(1) << S;
  localparam logic signed [VW-1:0] V_LIM  = VW'(1) << (S + 17);
  localparam logic signed [VW-1:0] V_NLIM = -V_LIM;

  // Configuration registers
  logic signed [20:0] cam_x_r;
  logic signed [16:0] cam_y_r;
  logic [19:0]        cam_z_r;
  logic [19:0]        trk_len_r;
  logic [15:0]        focal_r;
  logic [11:0]        scr_w_r;
  logic [11:0]        scr_h_r;
  logic [15:0]        road_w_r;

  // Segment and frame state
  logic signed [15:0] seg_h_r;
  logic [19:0]        seg_d_r;
  logic signed [15:0] seg_c_r;
  logic               wrap_r;
  logic signed [31:0] co_r;
  logic signed [23:0] cs_r;
  logic signed [15:0] ll_r;

  // Work registers
  logic signed [21:0]     dz_r;
  logic signed [25:0]     camx_r;
  logic signed [17:0]     hdiff_r;
  logic [20:0]            rem_r;
  logic [S-1:0]           quo_r;
  logic signed [P1W-1:0]  prod1_r;
  logic signed [P2W-1:0]  prod2_r;
  logic signed [15:0]     sx_r;
  logic signed [15:0]     sy_r;
  logic [15:0]            hw_r;

  // Output registers
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_sx_r;
  logic signed [15:0] out_sy_r;
  logic [15:0]        out_hw_r;
  logic [23:0]        out_scale_r;
  logic signed [15:0] out_clip_r;
  logic               out_vis_r;
  logic               out_ok_r;

  // Combinational values
  logic signed [21:0]    dz_c;
  logic signed [33:0]    diff_c;
  logic [33:0]           mag_c;
  logic [25:0]           camq_c;
  logic signed [25:0]    camx_c;
  logic signed [17:0]    hdiff_c;
  logic [21:0]           trial_c;
  logic [21:0]           dsub_c;
  logic                  ge_c;
  logic [20:0]           rem_nxt;
  logic signed [S:0]     m1_a;
  logic signed [25:0]    m1_b;
  logic signed [P1W-1:0] prod1_c;
  logic signed [VW-1:0]  p1_ext;
  logic signed [VW-1:0]  v_c;
  logic signed [VW-1:0]  vcl_c;
  logic signed [VCW-1:0] vc_c;
  logic signed [12:0]    m2_w;
  logic signed [P2W-1:0] prod2_c;
  logic signed [30:0]    q_c;
  logic signed [15:0]    q16s_c;
  logic [15:0]           q16u_c;
  logic                  dz_ok;
  logic                  vis_c;
  logic signed [32:0]    co_sum;
  logic signed [31:0]    co_nxt;
  logic signed [24:0]    cs_sum;
  logic signed [23:0]    cs_nxt;
  logic [32:0]           sc_ext;
  logic [23:0]           scale_sat_c;

  // Relative depth, lateral camera offset and height difference
  always_comb begin
    dz_c    = $signed({2'b00, seg_d_r}) - $signed({2'b00, cam_z_r})
              + (wrap_r ? $signed({2'b00, trk_len_r}) : 22'sd0);
    diff_c  = {{5{cam_x_r[20]}}, cam_x_r, 8'b0} - {{2{co_r[31]}}, co_r};
    mag_c   = diff_c[33] ? (34'd0 - diff_c) : diff_c;
    camq_c  = mag_c[33:8];
    camx_c  = diff_c[33] ? (26'd0 - camq_c) : camq_c;
    hdiff_c = {{2{seg_h_r[15]}}, seg_h_r} - {cam_y_r[16], cam_y_r};
  end

  assign dz_ok = !dz_r[21] && (|dz_r);

  // One restoring division step, one quotient bit
  always_comb begin
    trial_c = {rem_r, quo_r[S-1]};
    dsub_c  = trial_c - {1'b0, dz_r[20:0]};
    ge_c    = (trial_c >= {1'b0, dz_r[20:0]});
    rem_nxt = ge_c ? dsub_c[20:0] : trial_c[20:0];
  end

  // First multiplier: scale times lateral, height or road width
  always_comb begin
    m1_a = {1'b0, quo_r};
    case (cmd.m1_op)
      OP_X:    m1_b = camx_r;
      OP_Y:    m1_b = {{8{hdiff_r[17]}}, hdiff_r};
      OP_W:    m1_b = {10'b0, road_w_r};
      default: m1_b = '0;
    endcase
    prod1_c = m1_a * m1_b;
  end

  // Clamp the projected value, then scale by screen size
  always_comb begin
    p1_ext = {prod1_r[P1W-1], prod1_r};
    v_c    = (cmd.m2_op == OP_W) ? p1_ext : (V_ONE - p1_ext);
    if (v_c > V_LIM) begin
      vcl_c = V_LIM;
    end else if (v_c < V_NLIM) begin
      vcl_c = V_NLIM;
    end else begin
      vcl_c = v_c;
    end
    vc_c    = vcl_c[VCW-1:0];
    m2_w    = {1'b0, (cmd.m2_op == OP_Y) ? scr_h_r : scr_w_r};
    prod2_c = vc_c * m2_w;
  end

  // Floor shift and saturate to pixel range
  always_comb begin
    q_c = prod2_r[P2W-1:S+1];
    if (q_c > 31'sd32767) begin
      q16s_c = 16'sh7FFF;
    end else if (q_c < -31'sd32768) begin
      q16s_c = 16'sh8000;
    end else begin
      q16s_c = q_c[15:0];
    end
    if (q_c > 31'sd65535) begin
      q16u_c = 16'hFFFF;
    end else if (q_c < 31'sd0) begin
      q16u_c = 16'h0000;
    end else begin
      q16u_c = q_c[15:0];
    end
  end

  // Visibility, saturating curve advance and scale clamp
  always_comb begin
    vis_c  = dz_ok && (sy_r < ll_r);
    co_sum = {co_r[31], co_r} + {{9{cs_r[23]}}, cs_r};
    if (co_sum[32] != co_sum[31]) begin
      co_nxt = co_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      co_nxt = co_sum[31:0];
    end
    cs_sum = {cs_r[23], cs_r} + {{9{seg_c_r[15]}}, seg_c_r};
    if (cs_sum[24] != cs_sum[23]) begin
      cs_nxt = cs_sum[24] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end else begin
      cs_nxt = cs_sum[23:0];
    end
    sc_ext      = 33'(quo_r);
    scale_sat_c = (|sc_ext[32:24]) ? 24'hFF_FFFF : sc_ext[23:0];
  end

  assign out_valid_nxt = cmd.commit | (out_valid_r & out_stall);

  // Control state: configuration, curve, clip line and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= CAMERA_X_RST;
      cam_y_r     <= CAMERA_Y_RST;
      cam_z_r     <= CAMERA_Z_RST;
      trk_len_r   <= TRACK_LENGTH_RST;
      focal_r     <= FOCAL_DEPTH_RST;
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
      road_w_r    <= ROAD_WIDTH_RST;
      co_r        <= '0;
      cs_r        <= '0;
      ll_r        <= $signed({4'b0, SCREEN_H_RST});
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CAMERA_X:      cam_x_r   <= cfg_data[20:0];
          REG_CAMERA_Y:      cam_y_r   <= cfg_data[16:0];
          REG_CAMERA_Z:      cam_z_r   <= cfg_data[19:0];
          REG_TRACK_LENGTH:  trk_len_r <= cfg_data[19:0];
          REG_FOCAL_DEPTH:   focal_r   <= cfg_data[15:0];
          REG_SCREEN_WIDTH:  scr_w_r   <= cfg_data[11:0];
          REG_SCREEN_HEIGHT: scr_h_r   <= cfg_data[11:0];
          REG_ROAD_WIDTH:    road_w_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      // Clear curve and clip line at frame start, advance them at commit
      if (cmd.load && in_frame_start) begin
        co_r <= '0;
        cs_r <= '0;
        ll_r <= $signed({4'b0, scr_h_r});
      end else if (cmd.commit) begin
        co_r <= co_nxt;
        cs_r <= cs_nxt;
        if (vis_c) begin
          ll_r <= sy_r;
        end
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg_h_r <= in_seg_height;
      seg_d_r <= in_seg_depth;
      seg_c_r <= in_seg_curve;
      wrap_r  <= in_wrapped;
    end
    if (cmd.prep) begin
      dz_r    <= dz_c;
      camx_r  <= camx_c;
      hdiff_r <= hdiff_c;
      rem_r   <= '0;
      quo_r   <= S'(focal_r) << (S - 16);
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[S-2:0], ge_c};
    end
    if (cmd.m1_en) begin
      prod1_r <= prod1_c;
    end
    if (cmd.m2_en) begin
      prod2_r <= prod2_c;
    end
    if (cmd.sat_en) begin
      case (cmd.sat_op)
        OP_X:    sx_r <= q16s_c;
        OP_Y:    sy_r <= q16s_c;
        OP_W:    hw_r <= q16u_c;
        default: ;
      endcase
    end
    if (cmd.commit) begin
      out_sx_r    <= dz_ok ? sx_r : 16'sd0;
      out_sy_r    <= dz_ok ? sy_r : 16'sd0;
      out_hw_r    <= dz_ok ? hw_r : 16'd0;
      out_scale_r <= dz_ok ? scale_sat_c : 24'd0;
      out_clip_r  <= ll_r;
      out_vis_r   <= vis_c;
      out_ok_r    <= dz_ok;
    end
  end

  assign sts.dz_ok    = dz_ok;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid             = out_valid_r;
  assign out_screen_x          = out_sx_r;
  assign out_screen_y          = out_sy_r;
  assign out_screen_half_width = out_hw_r;
  assign out_proj_scale        = out_scale_r;
  assign out_clip_line         = out_clip_r;
  assign out_visible           = out_vis_r;
  assign out_depth_ok          = out_ok_r;

endmodule

`default_nettype wire

// File: src/pseudo3d_road_segment_projector.sv
// When the relative depth is not positive, the divide is skipped. The restoring
// divider yields one quotient bit per cycle and feeds a two-multiplier pipeline;
// a new item is taken only after the previous one has been committed.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset (synchronous, rst_n low): registers take defaults, curve clears, clip line = height.
`default_nettype none

module pseudo3d_road_segment_projector #(
  parameter int SCALE_FRAC_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  p3d_pkg::cfg_reg_t                   cfg_index,
  input  logic [p3d_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  in_seg_height,
  input  logic [19:0]                         in_seg_depth,
  input  logic signed [15:0]                  in_seg_curve,
  input  logic                                in_wrapped,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  out_screen_x,
  output logic signed [15:0]                  out_screen_y,
  output logic [15:0]                         out_screen_half_width,
  output logic [23:0]                         out_proj_scale,
  output logic signed [15:0]                  out_clip_line,
  output logic                                out_visible,
  output logic                                out_depth_ok
);
  import p3d_pkg::*;

  p3d_cmd_t cmd;
  p3d_sts_t sts;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  p3d_ctrl #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  p3d_dpath #(
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_seg_height         (in_seg_height),
    .in_seg_depth          (in_seg_depth),
    .in_seg_curve          (in_seg_curve),
    .in_wrapped            (in_wrapped),
    .in_frame_start        (in_frame_start),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_screen_x          (out_screen_x),
    .out_screen_y          (out_screen_y),
    .out_screen_half_width (out_screen_half_width),
    .out_proj_scale        (out_proj_scale),
    .out_clip_line         (out_clip_line),
    .out_visible           (out_visible),
    .out_depth_ok          (out_depth_ok)
  );

  // Commit only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed over a pending item");

  // An accepted item is prepared in the next cycle
  a_load_prep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.prep)
    else $error("accepted item not prepared");

  // No new item is taken while dividing
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> in_stall)
    else $error("input open during division");

  // A visible segment always has a valid depth
  a_vis_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |-> out_depth_ok)
    else $error("visible segment with invalid depth");

endmodule

`default_nettype wire
